@@ sv/mwbrp_pkg.sv @@
// shared types and constants of the mirrored window big-endian ram port
`timescale 1ns / 1ps
package mwbrp_pkg;

   localparam int RAM_BYTES = 65536;
   localparam int ADDR_W    = $clog2(RAM_BYTES);
   localparam int SIZE_W    = 17;
   localparam int VADDR_W   = 32;
   localparam int DATA_W    = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [SIZE_W-1:0] RAM_BYTES_C = SIZE_W'(RAM_BYTES);

   localparam logic [CSR_IDX_W-1:0] CSR_RAM_SIZE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CACHED_BASE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNCACHED_BASE = 2'd2;

   localparam logic [1:0] ASZ_BYTE = 2'd0;
   localparam logic [1:0] ASZ_HALF = 2'd1;
   localparam logic [1:0] ASZ_WORD = 2'd2;
   localparam logic [1:0] ASZ_NONE = 2'd3;

   localparam logic WIN_CACHED   = 1'b0;
   localparam logic WIN_UNCACHED = 1'b1;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic              hit;
      logic              fits;
      logic [ADDR_W-1:0] off;
   } map_res_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } ram_req_type;

endpackage

@@ sv/mwbrp_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps
module mwbrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/mwbrp_map.sv @@
// shared window unit: offset subtract, hit compare and end-of-ram check
`timescale 1ns / 1ps
module mwbrp_map (
   input  logic                         sel,
   input  logic [mwbrp_pkg::VADDR_W-1:0] vaddr,
   input  logic [mwbrp_pkg::VADDR_W-1:0] cached_base,
   input  logic [mwbrp_pkg::VADDR_W-1:0] uncached_base,
   input  logic [mwbrp_pkg::SIZE_W-1:0]  size,
   input  logic [2:0]                    nbytes,
   output mwbrp_pkg::map_res_type        res
);

   logic [mwbrp_pkg::VADDR_W-1:0] base;
   logic [mwbrp_pkg::VADDR_W-1:0] diff;
   logic [mwbrp_pkg::SIZE_W:0]    end_sum;

   always_comb begin
      base    = (sel == mwbrp_pkg::WIN_UNCACHED) ? uncached_base : cached_base;
      diff    = vaddr - base;
      // only meaningful on a hit, where diff is below size
      end_sum = {1'b0, diff[mwbrp_pkg::SIZE_W-1:0]} + (mwbrp_pkg::SIZE_W+1)'(nbytes);
      res.hit  = diff < mwbrp_pkg::VADDR_W'(size);
      res.fits = end_sum <= {1'b0, size};
      res.off  = diff[mwbrp_pkg::ADDR_W-1:0];
   end

endmodule

@@ sv/mwbrp_seq.sv @@
// access sequencer: clear pass, window lookups, byte-serial ram access, result register
`timescale 1ns / 1ps
module mwbrp_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          cmd,
   input  logic [1:0]                    access_size,
   input  logic [mwbrp_pkg::VADDR_W-1:0] vaddr,
   input  logic [mwbrp_pkg::DATA_W-1:0]  write_data,
   output logic                          map_sel,
   output logic [mwbrp_pkg::VADDR_W-1:0] map_vaddr,
   output logic [2:0]                    map_nbytes,
   input  mwbrp_pkg::map_res_type        map_res,
   output mwbrp_pkg::ram_req_type        ram_req,
   input  logic [7:0]                    ram_q,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mwbrp_pkg::DATA_W-1:0]  rsp_data,
   output logic                          rsp_fault
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAPC,
      ST_MAPU,
      ST_ACCESS,
      ST_DONE
   } state_type;

   state_type                     state_ff;
   logic [mwbrp_pkg::ADDR_W-1:0]  clr_ff;
   logic                          cmd_ff;
   logic [1:0]                    last_ff;
   logic [1:0]                    count_ff;
   logic [mwbrp_pkg::VADDR_W-1:0] vaddr_ff;
   logic [mwbrp_pkg::DATA_W-1:0]  wdata_ff;
   logic [mwbrp_pkg::DATA_W-1:0]  rdata_ff;
   logic [mwbrp_pkg::ADDR_W-1:0]  off_ff;
   logic                          fault_ff;
   logic                          rd_pend_ff;
   logic                          rsp_valid_ff;
   logic [mwbrp_pkg::DATA_W-1:0]  rsp_data_ff;
   logic                          rsp_fault_ff;

   logic [mwbrp_pkg::DATA_W-1:0]  rdata_in;
   logic                          out_free;
   logic                          accept;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign map_sel    = (state_ff == ST_MAPU) ? mwbrp_pkg::WIN_UNCACHED
                                             : mwbrp_pkg::WIN_CACHED;
   assign map_vaddr  = vaddr_ff;
   assign map_nbytes = {1'b0, last_ff} + 3'd1;

   // the read issued in the previous cycle lands here
   assign rdata_in = rd_pend_ff ? {rdata_ff[mwbrp_pkg::DATA_W-9:0], ram_q} : rdata_ff;

   always_comb begin
      ram_req.we    = 1'b0;
      ram_req.addr  = off_ff + mwbrp_pkg::ADDR_W'(count_ff);
      ram_req.wdata = wdata_ff[mwbrp_pkg::DATA_W-1 -: 8];
      if (state_ff == ST_CLEAR) begin
         ram_req.we    = 1'b1;
         ram_req.addr  = clr_ff;
         ram_req.wdata = 8'd0;
      end else if (state_ff == ST_ACCESS) begin
         ram_req.we = (cmd_ff == mwbrp_pkg::CMD_WRITE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff   <= (state_ff == ST_ACCESS) && (cmd_ff == mwbrp_pkg::CMD_READ);
         rdata_ff     <= accept ? '0 : rdata_in;
         // a taken result drops unless the next one is posted in the same cycle
         rsp_valid_ff <= ((state_ff == ST_DONE) && out_free) || (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + mwbrp_pkg::ADDR_W'(1);
               if (clr_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff   <= cmd;
                  vaddr_ff <= vaddr;
                  count_ff <= 2'd0;
                  fault_ff <= (access_size == mwbrp_pkg::ASZ_NONE);
                  state_ff <= (access_size == mwbrp_pkg::ASZ_NONE) ? ST_DONE : ST_MAPC;
                  // left-align the write bytes so the first byte sits on top
                  unique case (access_size)
                     mwbrp_pkg::ASZ_BYTE: begin
                        last_ff  <= 2'd0;
                        wdata_ff <= write_data << 24;
                     end
                     mwbrp_pkg::ASZ_HALF: begin
                        last_ff  <= 2'd1;
                        wdata_ff <= write_data << 16;
                     end
                     mwbrp_pkg::ASZ_WORD: begin
                        last_ff  <= 2'd3;
                        wdata_ff <= write_data;
                     end
                     mwbrp_pkg::ASZ_NONE: begin
                        last_ff  <= 2'd0;
                        wdata_ff <= write_data;
                     end
                  endcase
               end
            end
            ST_MAPC, ST_MAPU: begin
               if (map_res.hit) begin
                  off_ff   <= map_res.off;
                  fault_ff <= !map_res.fits;
                  state_ff <= map_res.fits ? ST_ACCESS : ST_DONE;
               end else if (state_ff == ST_MAPC) begin
                  state_ff <= ST_MAPU;
               end else begin
                  fault_ff <= 1'b1;
                  state_ff <= ST_DONE;
               end
            end
            ST_ACCESS: begin
               wdata_ff <= wdata_ff << 8;
               count_ff <= count_ff + 2'd1;
               if (count_ff == last_ff) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_data_ff  <= rdata_in;
                  rsp_fault_ff <= fault_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_fault = rsp_fault_ff;

endmodule

@@ sv/mirrored_window_bigendian_ram_port.sv @@
// top level of the mirrored window big-endian ram port
//
//   channel | dir | handshake              | payload
//   req     | in  | req_tvalid/req_tready  | tdata: access_size, vaddr, write_data; tuser: cmd
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata: read_data; tuser: fault
//   csr     | in  | csr_we                 | csr_index, csr_wdata
//
// an item passes through accept, one or two window lookups through the
// shared subtract/compare unit, then one cycle per byte on the single ram port
// and posting of the result; an unused access size skips straight to the result.
// after reset the ram is swept to zero, all 65536 bytes, one byte a cycle, with req_tready low.
// a result not taken holds in the output register; the next item is accepted meanwhile.
`timescale 1ns / 1ps
module mirrored_window_bigendian_ram_port (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [71:0]                       req_tdata,  // access_size, vaddr, write_data
   input  logic [0:0]                        req_tuser,  // cmd
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // read_data
   output logic [0:0]                        rsp_tuser,  // fault
   input  logic                              csr_we,
   input  logic [mwbrp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_wdata
);

   logic [mwbrp_pkg::SIZE_W-1:0]  ram_size_ff;
   logic [mwbrp_pkg::VADDR_W-1:0] cached_base_ff;
   logic [mwbrp_pkg::VADDR_W-1:0] uncached_base_ff;
   logic [mwbrp_pkg::SIZE_W-1:0]  size;

   logic                          map_sel;
   logic [mwbrp_pkg::VADDR_W-1:0] map_vaddr;
   logic [2:0]                    map_nbytes;
   mwbrp_pkg::map_res_type        map_res;
   mwbrp_pkg::ram_req_type        ram_req;
   logic [7:0]                    ram_q;
   logic [mwbrp_pkg::DATA_W-1:0]  rsp_data;
   logic                          rsp_fault;

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_size_ff      <= mwbrp_pkg::SIZE_W'(65536);
         cached_base_ff   <= 32'h8000_0000;
         uncached_base_ff <= 32'hC000_0000;
      end else if (csr_we) begin
         unique case (csr_index)
            mwbrp_pkg::CSR_RAM_SIZE:      ram_size_ff <= csr_wdata[mwbrp_pkg::SIZE_W-1:0];
            mwbrp_pkg::CSR_CACHED_BASE:   cached_base_ff   <= csr_wdata;
            mwbrp_pkg::CSR_UNCACHED_BASE: uncached_base_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // sizes beyond the physical ram are clamped
   assign size = (ram_size_ff > mwbrp_pkg::RAM_BYTES_C) ? mwbrp_pkg::RAM_BYTES_C : ram_size_ff;

   mwbrp_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .cmd         (req_tuser[0]),
      .access_size (req_tdata[1:0]),
      .vaddr       (req_tdata[33:2]),
      .write_data  (req_tdata[65:34]),
      .map_sel     (map_sel),
      .map_vaddr   (map_vaddr),
      .map_nbytes  (map_nbytes),
      .map_res     (map_res),
      .ram_req     (ram_req),
      .ram_q       (ram_q),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_data    (rsp_data),
      .rsp_fault   (rsp_fault)
   );

   mwbrp_map u_map (
      .sel           (map_sel),
      .vaddr         (map_vaddr),
      .cached_base   (cached_base_ff),
      .uncached_base (uncached_base_ff),
      .size          (size),
      .nbytes        (map_nbytes),
      .res           (map_res)
   );

   mwbrp_ram #(
      .WIDTH (8),
      .DEPTH (mwbrp_pkg::RAM_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_q)
   );

   assign rsp_tdata = rsp_data;
   assign rsp_tuser = rsp_fault;

endmodule

@@ sv/mwbrp_checker.sv @@
// port-level checker for the mirrored window big-endian ram port
`timescale 1ns / 1ps
module mwbrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // the clear pass keeps the input closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high right after reset");

   // an accepted item keeps the sequencer busy, so req_tready drops after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted in back-to-back cycles");

   // a faulting access returns zero data
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("fault result with nonzero read_data");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed or dropped");

endmodule

bind mirrored_window_bigendian_ram_port mwbrp_checker u_checker (.*);
